>>> hdl/i2cme_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i2cme_pkg
// Shared types and constants of the I2C master byte engine.
// ----------------------------------------------------------------------------
package i2cme_pkg;

  localparam int unsigned PADDR_W   = 3;
  localparam int unsigned PDATA_W   = 32;
  localparam int unsigned HP_W      = 16;
  localparam int unsigned TDATA_W   = 16;
  localparam int unsigned TUSER_W   = 3;

  localparam logic [3:0]      BITS_PER_BYTE  = 4'd8;
  localparam logic [HP_W-1:0] HALF_PERIOD_RST = 16'd4000;

  // register index taken from paddr[2]
  localparam logic REG_HALF_PERIOD = 1'b0;

  typedef logic [2:0] mode_t;
  localparam mode_t MODE_TICK    = 3'd0;
  localparam mode_t MODE_START   = 3'd1;
  localparam mode_t MODE_RESTART = 3'd2;
  localparam mode_t MODE_STOP    = 3'd3;
  localparam mode_t MODE_WRITE   = 3'd4;
  localparam mode_t MODE_READ    = 3'd5;

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_START   = 6'b000010,
    ST_RESTART = 6'b000100,
    ST_STOP    = 6'b001000,
    ST_WRITE   = 6'b010000,
    ST_READ    = 6'b100000
  } cmd_t;

  typedef struct packed {
    logic       sda_in;
    logic       send_nack;
    logic [7:0] wr_data;
    mode_t      mode;
  } item_t;

  typedef struct packed {
    logic       ack_received;
    logic [7:0] rd_data;
    logic       done_res;
    logic       busy_res;
    logic       sda_out;
    logic       scl_out;
  } result_t;

endpackage
`default_nettype wire

>>> hdl/i2cme_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i2cme_cfg
// APB register file: half period length in ticks.
// ----------------------------------------------------------------------------
module i2cme_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [i2cme_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [i2cme_pkg::PDATA_W-1:0]  pwdata,
  output logic      [i2cme_pkg::PDATA_W-1:0]  prdata,
  output logic                                pready,
  output logic      [i2cme_pkg::HP_W-1:0]     half_period_ticks
);
  import i2cme_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready & (paddr[2] == REG_HALF_PERIOD);

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period_ticks <= HALF_PERIOD_RST;
    end else if (wr_en) begin
      half_period_ticks <= pwdata[HP_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_HALF_PERIOD) begin
      prdata[HP_W-1:0] = half_period_ticks;
    end
  end

endmodule
`default_nettype wire

>>> hdl/i2cme_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i2cme_core
// Bit engine state and its registered update for one tick or command.
// ----------------------------------------------------------------------------
module i2cme_core (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        go,
  input  wire i2cme_pkg::item_t            item,
  input  wire logic [i2cme_pkg::HP_W-1:0]  half_period_ticks,
  output i2cme_pkg::result_t               res
);
  import i2cme_pkg::*;

  cmd_t            cmd, cmd_next;
  logic [4:0]      phase, phase_next;
  logic [3:0]      bit_count, bit_count_next;
  logic [7:0]      shift_byte, shift_byte_next;
  logic [HP_W-1:0] divider_count, divider_count_next;
  logic            scl_level, scl_level_next;
  logic            sda_level, sda_level_next;
  logic            ack_flag, ack_flag_next;
  logic            nack_choice, nack_choice_next;
  logic [7:0]      last_read, last_read_next;

  logic [HP_W-1:0] div_inc;
  logic [HP_W-1:0] hp;
  logic [3:0]      bc_inc;
  logic            rd;
  logic            finish;

  assign div_inc = divider_count + 16'd1;
  assign hp      = (half_period_ticks == '0) ? 16'd1 : half_period_ticks;
  assign bc_inc  = bit_count + 4'd1;
  assign rd      = (cmd == ST_READ);

  always_comb begin
    cmd_next           = cmd;
    phase_next         = phase;
    bit_count_next     = bit_count;
    shift_byte_next    = shift_byte;
    divider_count_next = divider_count;
    scl_level_next     = scl_level;
    sda_level_next     = sda_level;
    ack_flag_next      = ack_flag;
    nack_choice_next   = nack_choice;
    last_read_next     = last_read;
    finish             = 1'b0;

    if (go) begin
      if (item.mode == MODE_TICK) begin
        if (cmd != ST_IDLE) begin
          if ((div_inc < hp) && (div_inc != '0)) begin
            divider_count_next = div_inc;
          end else begin
            divider_count_next = '0;
            phase_next         = phase + 5'd1;
            unique case (cmd)
              ST_START: begin
                priority if (phase == 5'd0) sda_level_next = 1'b0;
                else if (phase == 5'd1) scl_level_next = 1'b0;
                else finish = 1'b1;
              end
              ST_RESTART: begin
                priority if (phase == 5'd0) scl_level_next = 1'b1;
                else if (phase == 5'd1) sda_level_next = 1'b0;
                else if (phase == 5'd2) scl_level_next = 1'b0;
                else finish = 1'b1;
              end
              ST_STOP: begin
                priority if (phase == 5'd0) scl_level_next = 1'b1;
                else if (phase == 5'd1) sda_level_next = 1'b1;
                else finish = 1'b1;
              end
              ST_WRITE, ST_READ: begin
                if (!phase[0]) begin
                  scl_level_next = 1'b1;
                end else begin
                  scl_level_next = 1'b0;
                  if (bit_count < BITS_PER_BYTE) begin
                    shift_byte_next = {shift_byte[6:0], rd & item.sda_in};
                    bit_count_next  = bc_inc;
                    if (bc_inc < BITS_PER_BYTE) begin
                      sda_level_next = rd ? 1'b1 : shift_byte[6];
                    end else begin
                      sda_level_next = rd ? nack_choice : 1'b1;
                    end
                  end else begin
                    if (rd) begin
                      last_read_next = shift_byte;
                      sda_level_next = 1'b1;
                    end else begin
                      ack_flag_next = ~item.sda_in;
                    end
                    finish = 1'b1;
                  end
                end
              end
              default: begin
              end
            endcase
            if (finish) begin
              cmd_next           = ST_IDLE;
              phase_next         = '0;
              bit_count_next     = '0;
              divider_count_next = '0;
            end
          end
        end
      end else if (cmd == ST_IDLE) begin
        phase_next         = '0;
        bit_count_next     = '0;
        divider_count_next = '0;
        unique case (item.mode)
          MODE_START: begin
            cmd_next       = ST_START;
            sda_level_next = 1'b1;
            scl_level_next = 1'b1;
          end
          MODE_RESTART: begin
            cmd_next       = ST_RESTART;
            sda_level_next = 1'b1;
          end
          MODE_STOP: begin
            cmd_next       = ST_STOP;
            sda_level_next = 1'b0;
          end
          MODE_WRITE: begin
            cmd_next        = ST_WRITE;
            shift_byte_next = item.wr_data;
            scl_level_next  = 1'b0;
            sda_level_next  = item.wr_data[7];
          end
          MODE_READ: begin
            cmd_next         = ST_READ;
            shift_byte_next  = '0;
            nack_choice_next = item.send_nack;
            scl_level_next   = 1'b0;
            sda_level_next   = 1'b1;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_comb begin
    res.scl_out      = scl_level_next;
    res.sda_out      = sda_level_next;
    res.busy_res     = (cmd_next != ST_IDLE);
    res.done_res     = finish;
    res.rd_data      = last_read_next;
    res.ack_received = ack_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd           <= ST_IDLE;
      phase         <= '0;
      bit_count     <= '0;
      shift_byte    <= '0;
      divider_count <= '0;
      scl_level     <= 1'b1;
      sda_level     <= 1'b1;
      ack_flag      <= 1'b0;
      nack_choice   <= 1'b0;
      last_read     <= '0;
    end else begin
      cmd           <= cmd_next;
      phase         <= phase_next;
      bit_count     <= bit_count_next;
      shift_byte    <= shift_byte_next;
      divider_count <= divider_count_next;
      scl_level     <= scl_level_next;
      sda_level     <= sda_level_next;
      ack_flag      <= ack_flag_next;
      nack_choice   <= nack_choice_next;
      last_read     <= last_read_next;
    end
  end

endmodule
`default_nettype wire

>>> hdl/i2cme_outbuf.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i2cme_outbuf
// Two-entry result buffer: output register plus skid entry.
// ----------------------------------------------------------------------------
module i2cme_outbuf (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire i2cme_pkg::result_t  din,
  output logic                     space,
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output i2cme_pkg::result_t       dout
);
  import i2cme_pkg::*;

  result_t    ob0, ob1;
  logic [1:0] cnt;
  logic       pop;

  assign space    = (cnt != 2'd2);
  assign m_tvalid = (cnt != 2'd0);
  assign pop      = m_tvalid & m_tready;
  assign dout     = ob0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      ob0 <= (push && cnt == 2'd1) ? din : ob1;
    end else if (push && cnt == 2'd0) begin
      ob0 <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !pop && cnt == 2'd1) begin
      ob1 <= din;
    end
  end

endmodule
`default_nettype wire

>>> hdl/i2c_master_byte_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i2c_master_byte_engine
// I2C master bit engine driven by tick and command transactions.
// ----------------------------------------------------------------------------
// Each input transaction is held in the input register, then its result is
// written into the result buffer and offered on m_tvalid.
// Throughput: one transaction per cycle; the input stalls only while both
// result buffer entries are held.
// Reset (rst, synchronous): engine idle, SCL and SDA released, half period
// 4000 ticks, result buffer and input register empty.
// ----------------------------------------------------------------------------
module i2c_master_byte_engine (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  // [7:0] wr_data, [8] send_nack, [9] sda_in, [15:10] zero
  input  wire logic [i2cme_pkg::TDATA_W-1:0]  s_tdata,
  // [2:0] mode
  input  wire logic [i2cme_pkg::TUSER_W-1:0]  s_tuser,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  // [0] scl_out, [1] sda_out, [2] busy_res, [3] done_res, [11:4] rd_data,
  // [12] ack_received, [15:13] zero
  output logic      [i2cme_pkg::TDATA_W-1:0]  m_tdata,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [i2cme_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [i2cme_pkg::PDATA_W-1:0]  pwdata,
  output logic      [i2cme_pkg::PDATA_W-1:0]  prdata,
  output logic                                pready
);
  import i2cme_pkg::*;

  logic            in_v;
  item_t           in_item;
  logic            go;
  logic            buf_space;
  result_t         res;
  result_t         out_res;
  logic [HP_W-1:0] half_period_ticks;

  assign s_tready = ~in_v | buf_space;
  assign go       = in_v & buf_space;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_v <= 1'b1;
    end else if (go) begin
      in_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.mode      <= s_tuser;
      in_item.wr_data   <= s_tdata[7:0];
      in_item.send_nack <= s_tdata[8];
      in_item.sda_in    <= s_tdata[9];
    end
  end

  i2cme_cfg u_cfg (
    .clk               (clk),
    .rst               (rst),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .half_period_ticks (half_period_ticks)
  );

  i2cme_core u_core (
    .clk               (clk),
    .rst               (rst),
    .go                (go),
    .item              (in_item),
    .half_period_ticks (half_period_ticks),
    .res               (res)
  );

  i2cme_outbuf u_outbuf (
    .clk      (clk),
    .rst      (rst),
    .push     (go),
    .din      (res),
    .space    (buf_space),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .dout     (out_res)
  );

  assign m_tdata = {3'b000, out_res};

  a_go_has_space: assert property (@(posedge clk) disable iff (rst)
    go |-> buf_space)
    else $error("result pushed into full buffer");

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    (go && res.done_res) |-> !res.busy_res)
    else $error("done reported while still busy");

  a_stall_holds_item: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> in_v)
    else $error("input stalled with empty input register");

  a_accept_loads: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> in_v)
    else $error("accepted transaction lost");

endmodule
`default_nettype wire

>>> dv/i2c_master_byte_engine_tb.sv
// ----------------------------------------------------------------------------
// i2c_master_byte_engine_tb
// Drives tick and command transactions into the I2C byte engine and predicts
// each SCL/SDA and status word in order. Covers the reset half period,
// directed protocol cases, random bus transfers with noise, and the extreme
// half-period settings.
// ----------------------------------------------------------------------------
module i2c_master_byte_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import i2cme_pkg::*;

  localparam logic [PADDR_W-1:0] ADDR_HALF_PERIOD = 3'd0;
  localparam logic [PADDR_W-1:0] ADDR_SPARE       = 3'd4;
  localparam mode_t              CMD_NONE         = MODE_TICK;
  localparam int                 QUIET_LIMIT      = 3000;
  localparam int                 HOLDOFF_CYCLES   = 400;
  localparam int                 SDA_RANDOM       = -1;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_COMB} rx_style_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [TDATA_W-1:0]  s_tdata = '0;
  logic [TUSER_W-1:0]  s_tuser = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [TDATA_W-1:0]  m_tdata;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [PDATA_W-1:0]  pwdata = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  i2c_master_byte_engine dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // engine prediction state
  mode_t       eng_cmd;
  logic [4:0]  eng_phase;
  logic [3:0]  eng_bits;
  logic [7:0]  eng_shift;
  logic [15:0] eng_div;
  logic        eng_scl;
  logic        eng_sda;
  logic        eng_ack;
  logic        eng_nack;
  logic [7:0]  eng_last_rd;
  logic [15:0] eng_half;

  item_t   pending_bus_items[$];
  result_t expected_status[$];
  item_t   on_bus;
  int unsigned mismatches = 0;
  int unsigned status_seen = 0;
  int unsigned queued_count = 0;
  int          gen_hp = 4000;
  bit          allow_intrusion = 1'b0;
  bit          holdoff_request = 1'b0;

  task automatic note_mismatch(input string what, input int unsigned got,
                               input int unsigned want);
    $display("MISMATCH %s: got %0h expected %0h (result %0d)", what, got, want,
             status_seen);
    mismatches++;
  endtask

  function automatic void end_command();
    eng_cmd   = CMD_NONE;
    eng_phase = '0;
    eng_bits  = '0;
    eng_div   = '0;
  endfunction

  function automatic void advance_engine(input item_t it);
    logic        done;
    logic        rd;
    logic [15:0] hp;
    result_t     r;
    done = 1'b0;
    if (it.mode == MODE_TICK) begin
      if (eng_cmd != CMD_NONE) begin
        hp = (eng_half == 16'd0) ? 16'd1 : eng_half;
        eng_div = eng_div + 16'd1;
        if (!(eng_div < hp && eng_div != 16'd0)) begin
          eng_div = '0;
          case (eng_cmd)
            MODE_START: begin
              if (eng_phase == 5'd0) eng_sda = 1'b0;
              else if (eng_phase == 5'd1) eng_scl = 1'b0;
              else done = 1'b1;
            end
            MODE_RESTART: begin
              if (eng_phase == 5'd0) eng_scl = 1'b1;
              else if (eng_phase == 5'd1) eng_sda = 1'b0;
              else if (eng_phase == 5'd2) eng_scl = 1'b0;
              else done = 1'b1;
            end
            MODE_STOP: begin
              if (eng_phase == 5'd0) eng_scl = 1'b1;
              else if (eng_phase == 5'd1) eng_sda = 1'b1;
              else done = 1'b1;
            end
            default: begin
              rd = (eng_cmd == MODE_READ);
              if (!eng_phase[0]) begin
                eng_scl = 1'b1;
              end else begin
                eng_scl = 1'b0;
                if (eng_bits < BITS_PER_BYTE) begin
                  eng_shift = {eng_shift[6:0], rd ? it.sda_in : 1'b0};
                  eng_bits  = eng_bits + 4'd1;
                  if (eng_bits < BITS_PER_BYTE) eng_sda = rd ? 1'b1 : eng_shift[7];
                  else eng_sda = rd ? eng_nack : 1'b1;
                end else begin
                  if (rd) begin
                    eng_last_rd = eng_shift;
                    eng_sda     = 1'b1;
                  end else begin
                    eng_ack = ~it.sda_in;
                  end
                  done = 1'b1;
                end
              end
            end
          endcase
          if (done) end_command();
          else eng_phase = eng_phase + 5'd1;
        end
      end
    end else if (it.mode <= MODE_READ && eng_cmd == CMD_NONE) begin
      eng_cmd   = it.mode;
      eng_phase = '0;
      eng_bits  = '0;
      eng_div   = '0;
      case (it.mode)
        MODE_START: begin
          eng_sda = 1'b1;
          eng_scl = 1'b1;
        end
        MODE_RESTART: eng_sda = 1'b1;
        MODE_STOP:    eng_sda = 1'b0;
        MODE_WRITE: begin
          eng_shift = it.wr_data;
          eng_scl   = 1'b0;
          eng_sda   = it.wr_data[7];
        end
        default: begin
          eng_shift = '0;
          eng_nack  = it.send_nack;
          eng_scl   = 1'b0;
          eng_sda   = 1'b1;
        end
      endcase
    end
    r.scl_out      = eng_scl;
    r.sda_out      = eng_sda;
    r.busy_res     = (eng_cmd != CMD_NONE);
    r.done_res     = done;
    r.rd_data      = eng_last_rd;
    r.ack_received = eng_ack;
    expected_status.push_back(r);
  endfunction

  // stimulus builders
  function automatic void queue_item(input mode_t m, input logic [7:0] d,
                                     input logic nack, input logic sda);
    item_t it;
    it.mode      = m;
    it.wr_data   = d;
    it.send_nack = nack;
    it.sda_in    = sda;
    pending_bus_items.push_back(it);
    queued_count++;
  endfunction

  function automatic void queue_ticks(input int n, input int sda);
    for (int i = 0; i < n; i++)
      queue_item(MODE_TICK, 8'($urandom), 1'($urandom_range(0, 1)),
                 (sda < 0) ? 1'($urandom_range(0, 1)) : sda[0]);
  endfunction

  function automatic void queue_command(input mode_t m, input logic [7:0] d,
                                        input logic nack, input int sda);
    int n;
    int at;
    case (m)
      MODE_START, MODE_STOP: n = 3 * gen_hp;
      MODE_RESTART:          n = 4 * gen_hp;
      default:               n = 18 * gen_hp;
    endcase
    at = (allow_intrusion && $urandom_range(0, 7) == 0) ? $urandom_range(0, n - 1) : -1;
    queue_item(m, d, nack, 1'($urandom_range(0, 1)));
    for (int i = 0; i < n; i++) begin
      if (i == at)
        queue_item(mode_t'($urandom_range(1, 7)), 8'($urandom),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      queue_ticks(1, sda);
    end
  endfunction

  function automatic void queue_random_byte();
    queue_command($urandom_range(0, 1) ? MODE_WRITE : MODE_READ, 8'($urandom),
                  1'($urandom_range(0, 1)), SDA_RANDOM);
  endfunction

  function automatic void queue_random_transfer();
    if ($urandom_range(0, 6) == 0) begin
      repeat ($urandom_range(1, 6)) begin
        queue_item(mode_t'($urandom_range(0, 7)), 8'($urandom),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        queue_ticks($urandom_range(0, 20 * gen_hp), SDA_RANDOM);
      end
      queue_ticks(18 * gen_hp, SDA_RANDOM);
    end else begin
      queue_command(MODE_START, 8'($urandom), 1'($urandom_range(0, 1)), SDA_RANDOM);
      repeat ($urandom_range(1, 4)) queue_random_byte();
      if ($urandom_range(0, 2) == 0) begin
        queue_command(MODE_RESTART, 8'($urandom), 1'($urandom_range(0, 1)), SDA_RANDOM);
        repeat ($urandom_range(1, 2)) queue_random_byte();
      end
      queue_command(MODE_STOP, 8'($urandom), 1'($urandom_range(0, 1)), SDA_RANDOM);
      if ($urandom_range(0, 1)) queue_ticks($urandom_range(1, 3), SDA_RANDOM);
    end
  endfunction

  function automatic void queue_random_phase(input int count);
    int unsigned first;
    first = queued_count;
    while (queued_count - first < count) queue_random_transfer();
  endfunction

  task automatic drain();
    while (pending_bus_items.size() > 0 || s_tvalid || expected_status.size() > 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == ADDR_HALF_PERIOD) eng_half = data[15:0];
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apb_read(input logic [PADDR_W-1:0] addr);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {16'd0, eng_half}) note_mismatch("prdata", prdata, {16'd0, eng_half});
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_half_period(input logic [15:0] hp);
    apb_write(ADDR_HALF_PERIOD, {16'd0, hp});
    gen_hp = (hp == 16'd0) ? 1 : hp;
  endtask

  // sender: bursts of random length with random gaps
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin : feed
    item_t nxt;
    if (rst) begin
      s_tvalid   <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (s_tvalid && s_tready) advance_engine(on_bus);
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (pending_bus_items.size() > 0) begin
          nxt = pending_bus_items.pop_front();
          on_bus = nxt;
          s_tvalid <= 1'b1;
          s_tdata  <= {6'd0, nxt.sda_in, nxt.send_nack, nxt.wr_data};
          s_tuser  <= nxt.mode;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 48);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: stall pattern plus requested long hold-off
  rx_style_t rx_style = RX_OPEN;
  int        rx_style_left = 0;
  int        holdoff_left = 0;
  int unsigned rx_cycle = 0;

  always @(posedge clk) begin : collect
    result_t got;
    result_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      rx_cycle++;
      if (m_tvalid && m_tready) begin
        got = result_t'(m_tdata[$bits(result_t)-1:0]);
        if (expected_status.size() == 0) begin
          note_mismatch("result with nothing expected", m_tdata, 0);
        end else begin
          want = expected_status.pop_front();
          if (got.scl_out !== want.scl_out) note_mismatch("scl_out", got.scl_out, want.scl_out);
          if (got.sda_out !== want.sda_out) note_mismatch("sda_out", got.sda_out, want.sda_out);
          if (got.busy_res !== want.busy_res)
            note_mismatch("busy_res", got.busy_res, want.busy_res);
          if (got.done_res !== want.done_res)
            note_mismatch("done_res", got.done_res, want.done_res);
          if (got.rd_data !== want.rd_data) note_mismatch("rd_data", got.rd_data, want.rd_data);
          if (got.ack_received !== want.ack_received)
            note_mismatch("ack_received", got.ack_received, want.ack_received);
          if (m_tdata[TDATA_W-1:$bits(result_t)] !== '0)
            note_mismatch("tdata padding", m_tdata[TDATA_W-1:$bits(result_t)], 0);
        end
        status_seen++;
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        m_tready <= 1'b0;
      end else if (holdoff_request) begin
        holdoff_request = 1'b0;
        holdoff_left    = HOLDOFF_CYCLES;
        m_tready <= 1'b0;
      end else begin
        if (rx_style_left == 0) begin
          rx_style      = rx_style_t'($urandom_range(0, 3));
          rx_style_left = $urandom_range(16, 96);
        end else begin
          rx_style_left--;
        end
        case (rx_style)
          RX_OPEN:   m_tready <= 1'b1;
          RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
          RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
          default:   m_tready <= (rx_cycle % 5 != 0);
        endcase
      end
    end
  end

  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", quiet_cycles);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    eng_half    = HALF_PERIOD_RST;
    eng_last_rd = '0;
    eng_shift   = '0;
    eng_scl     = 1'b1;
    eng_sda     = 1'b1;
    eng_ack     = 1'b0;
    eng_nack    = 1'b0;
    end_command();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset half period: idle noise, then a start that stays in its first phase
    queue_item(mode_t'(6), 8'hFF, 1'b1, 1'b1);
    queue_item(mode_t'(7), 8'h00, 1'b0, 1'b0);
    queue_ticks(2, SDA_RANDOM);
    queue_item(MODE_START, 8'h00, 1'b0, 1'b0);
    queue_ticks(20, SDA_RANDOM);
    drain();
    apb_read(ADDR_HALF_PERIOD);

    set_half_period(16'd1);
    apb_write(ADDR_SPARE, $urandom);
    apb_read(ADDR_HALF_PERIOD);
    queue_ticks(4, SDA_RANDOM);

    // directed protocol cases
    queue_command(MODE_START, 8'h00, 1'b0, SDA_RANDOM);
    queue_item(MODE_WRITE, 8'hFF, 1'b0, 1'b0);
    queue_ticks(5, 0);
    queue_item(MODE_READ, 8'h3C, 1'b1, 1'b1);
    queue_ticks(13, 0);
    queue_command(MODE_WRITE, 8'h00, 1'b1, 1);
    queue_command(MODE_RESTART, 8'hFF, 1'b1, SDA_RANDOM);
    queue_command(MODE_READ, 8'h00, 1'b0, 1);
    queue_command(MODE_READ, 8'hFF, 1'b1, 0);
    queue_command(MODE_READ, 8'h5A, 1'b0, SDA_RANDOM);
    queue_command(MODE_STOP, 8'h00, 1'b0, SDA_RANDOM);
    queue_ticks(2, SDA_RANDOM);
    queue_command(MODE_WRITE, 8'hA5, 1'b0, SDA_RANDOM);
    queue_command(MODE_STOP, 8'h00, 1'b0, SDA_RANDOM);
    drain();

    allow_intrusion = 1'b1;
    set_half_period(16'd0);
    holdoff_request = 1'b1;
    queue_random_phase(180);
    drain();

    set_half_period(16'd2);
    queue_random_phase(100);
    drain();
    queue_random_phase(100);
    drain();

    set_half_period(16'd3);
    queue_random_phase(130);
    drain();

    set_half_period(16'hFFFF);
    queue_item(MODE_START, 8'h00, 1'b0, 1'b0);
    queue_ticks(40, SDA_RANDOM);
    drain();

    set_half_period(16'($urandom_range(1, 5)));
    queue_ticks(16, SDA_RANDOM);
    queue_random_phase(130);
    drain();

    set_half_period(16'd1);
    holdoff_request = 1'b1;
    queue_random_phase(130);
    drain();

    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
